// ----- rtl/kct_pkg.sv -----
// Shared types and constants for the keypad countdown timer.
package kct_pkg;

    localparam int DIGIT_W = 4;
    localparam int NUM_DIGITS = 4;
    localparam int CURSOR_W = 2;

    typedef logic [DIGIT_W-1:0] t_digit;

    typedef enum logic [1:0] {
        PH_ENTRY = 2'd0,
        PH_ARMED = 2'd1,
        PH_COUNT = 2'd2,
        PH_ALARM = 2'd3
    } t_phase;

    localparam logic ACT_KEY = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam t_digit KEY_DIGIT_MAX = 4'd9;
    localparam t_digit KEY_STAR = 4'd10;
    localparam t_digit KEY_HASH = 4'd11;

    localparam t_digit TENS_MAX = 4'd5;
    localparam t_digit ONES_MAX = 4'd9;

    localparam logic [CURSOR_W-1:0] CURSOR_LAST = 2'd3;

    typedef struct packed {
        t_digit                 tens_minutes;
        t_digit                 ones_minutes;
        t_digit                 tens_seconds;
        t_digit                 ones_seconds;
        t_phase                 phase;
        logic [CURSOR_W-1:0]    cursor;
        logic                   led_on;
    } t_state;

    localparam t_state STATE_CLEAR = '{
        tens_minutes: '0,
        ones_minutes: '0,
        tens_seconds: '0,
        ones_seconds: '0,
        phase:        PH_ENTRY,
        cursor:       '0,
        led_on:       1'b0
    };

endpackage

// ----- rtl/kct_step.sv -----
// Next-state logic: key entry, go with capping, BCD countdown and alarm.
module kct_step (
    input  kct_pkg::t_state     i_state,
    input  logic                i_action,
    input  kct_pkg::t_digit     i_key_code,
    output kct_pkg::t_state     o_state
);

    kct_pkg::t_state w_count;
    kct_pkg::t_state w_entry;
    kct_pkg::t_state w_go;
    logic            w_is_zero;

    // one-second tick while counting
    always_comb begin
        w_count = i_state;
        w_is_zero = (i_state.tens_minutes == '0) && (i_state.ones_minutes == '0)
                 && (i_state.tens_seconds == '0) && (i_state.ones_seconds == '0);
        if (w_is_zero) begin
            w_count.phase = kct_pkg::PH_ALARM;
            w_count.led_on = 1'b1;
        end else if (i_state.ones_seconds != '0) begin
            w_count.ones_seconds = i_state.ones_seconds - 4'd1;
        end else if (i_state.tens_seconds != '0) begin
            w_count.ones_seconds = kct_pkg::ONES_MAX;
            w_count.tens_seconds = i_state.tens_seconds - 4'd1;
        end else if (i_state.ones_minutes != '0) begin
            w_count.ones_seconds = kct_pkg::ONES_MAX;
            w_count.tens_seconds = kct_pkg::TENS_MAX;
            w_count.ones_minutes = i_state.ones_minutes - 4'd1;
        end else begin
            w_count.ones_seconds = kct_pkg::ONES_MAX;
            w_count.tens_seconds = kct_pkg::TENS_MAX;
            w_count.ones_minutes = kct_pkg::ONES_MAX;
            w_count.tens_minutes = i_state.tens_minutes - 4'd1;
        end
    end

    // digit written at the cursor
    always_comb begin
        w_entry = i_state;
        case (i_state.cursor)
            2'd0:    w_entry.tens_minutes = i_key_code;
            2'd1:    w_entry.ones_minutes = i_key_code;
            2'd2:    w_entry.tens_seconds = i_key_code;
            default: w_entry.ones_seconds = i_key_code;
        endcase
        if (i_state.cursor == kct_pkg::CURSOR_LAST) begin
            w_entry.phase = kct_pkg::PH_ARMED;
        end else begin
            w_entry.cursor = i_state.cursor + 2'd1;
        end
    end

    // go: cap each pair to 59
    always_comb begin
        w_go = i_state;
        w_go.phase = kct_pkg::PH_COUNT;
        if (i_state.tens_minutes > kct_pkg::TENS_MAX) begin
            w_go.tens_minutes = kct_pkg::TENS_MAX;
            w_go.ones_minutes = kct_pkg::ONES_MAX;
        end
        if (i_state.tens_seconds > kct_pkg::TENS_MAX) begin
            w_go.tens_seconds = kct_pkg::TENS_MAX;
            w_go.ones_seconds = kct_pkg::ONES_MAX;
        end
    end

    always_comb begin
        o_state = i_state;
        if (i_action == kct_pkg::ACT_TICK) begin
            if (i_state.phase == kct_pkg::PH_COUNT) begin
                o_state = w_count;
            end
        end else if (i_key_code == kct_pkg::KEY_STAR) begin
            o_state = kct_pkg::STATE_CLEAR;
        end else begin
            case (i_state.phase)
                kct_pkg::PH_ENTRY: begin
                    if (i_key_code <= kct_pkg::KEY_DIGIT_MAX) begin
                        o_state = w_entry;
                    end
                end
                kct_pkg::PH_ARMED: begin
                    if (i_key_code == kct_pkg::KEY_HASH) begin
                        o_state = w_go;
                    end
                end
                kct_pkg::PH_ALARM: begin
                    if (i_key_code == kct_pkg::KEY_HASH) begin
                        o_state = kct_pkg::STATE_CLEAR;
                    end
                end
                default: o_state = i_state;
            endcase
        end
    end

endmodule

// ----- rtl/keypad_countdown_timer.sv -----
// Top level of the keypad countdown timer: input register, step logic, state/result register.
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_action, i_key_code
//  out     | o_out_valid / i_out_ready | o_tens_minutes .. o_ones_seconds, o_phase,
//          |                           | o_entry_position, o_alarm_led
//
// A word passes through the input register, then through the step logic into
// the state register, which is also the result.
// One word per cycle is sustained while the output side takes words.
// Reset clears to 00:00 entry with the LED off; no words pending.
// A stall at the output holds the result; the input register still takes one word.
module keypad_countdown_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [3:0]  i_key_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_tens_minutes,
    output logic [3:0]  o_ones_minutes,
    output logic [3:0]  o_tens_seconds,
    output logic [3:0]  o_ones_seconds,
    output logic [1:0]  o_phase,
    output logic [1:0]  o_entry_position,
    output logic        o_alarm_led
);

    logic               r_in_valid;
    logic               r_action;
    kct_pkg::t_digit    r_key_code;
    logic               r_out_valid;
    kct_pkg::t_state    r_state;
    kct_pkg::t_state    n_state;
    logic               w_out_free;
    logic               w_fire;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action   <= i_action;
            r_key_code <= i_key_code;
        end
    end

    kct_step u_step (
        .i_state    (r_state),
        .i_action   (r_action),
        .i_key_code (r_key_code),
        .o_state    (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= kct_pkg::STATE_CLEAR;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_tens_minutes   = r_state.tens_minutes;
    assign o_ones_minutes   = r_state.ones_minutes;
    assign o_tens_seconds   = r_state.tens_seconds;
    assign o_ones_seconds   = r_state.ones_seconds;
    assign o_phase          = r_state.phase;
    assign o_entry_position = r_state.cursor;
    assign o_alarm_led      = r_state.led_on;

    a_led_in_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.led_on == (r_state.phase == kct_pkg::PH_ALARM))
        else $error("LED disagrees with alarm phase");

    a_cursor_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != kct_pkg::PH_ENTRY |-> r_state.cursor == kct_pkg::CURSOR_LAST)
        else $error("cursor not parked outside entry");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without a full pipeline");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_state))
        else $error("state changed without a word");

    a_tens_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == kct_pkg::PH_COUNT |->
            r_state.tens_minutes <= kct_pkg::TENS_MAX
            && r_state.tens_seconds <= kct_pkg::TENS_MAX)
        else $error("tens digit above five while counting");

endmodule
